[rtl/core/pese_pkg.sv]
// Package for the prefix expression evaluator: widths, operator codes,
// word types for both channels and the controller/datapath command structs.
// No dependencies.
`default_nettype none

package pese_pkg;

	// Data width of one stack entry and of every operand.
	localparam int DATA_W = 32;
	localparam int CODE_W = 3;
	localparam int STACK_DEPTH_DEF = 16;
	// Bits of the divider step counter.
	localparam int DIV_CNT_W = $clog2(DATA_W);

	// Token kinds.
	localparam logic KIND_OPERAND = 1'b0;
	localparam logic KIND_OPERATOR = 1'b1;

	// Operator codes.
	localparam logic [CODE_W-1:0] OP_ADD = 3'd0;
	localparam logic [CODE_W-1:0] OP_MUL = 3'd1;
	localparam logic [CODE_W-1:0] OP_SUB = 3'd2;
	localparam logic [CODE_W-1:0] OP_DIV = 3'd3;
	localparam logic [CODE_W-1:0] OP_REM = 3'd4;

	// Token word on the input channel.
	typedef struct packed {
		logic kind;
		logic signed [DATA_W-1:0] operand_value;
		logic [CODE_W-1:0] operator_code;
		logic last_token;
	} tok_t;

	// Result word on the output channel.
	typedef struct packed {
		logic signed [DATA_W-1:0] result_value;
		logic underflow_seen;
		logic overflow_seen;
		logic divide_by_zero_seen;
	} res_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_tok;
		logic push_opnd;
		logic push_res;
		logic pop;
		logic cap_a;
		logic cap_b;
		logic alu;
		logic div_start;
		logic div_cap;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic kind;
		logic code_ok;
		logic is_div;
		logic last;
		logic b_zero;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

[rtl/core/pese_tok_if.sv]
// Token channel: valid/ready handshake carrying one token word.
// Depends on pese_pkg.
`default_nettype none

interface pese_tok_if;
	logic valid;
	logic ready;
	pese_pkg::tok_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/pese_res_if.sv]
// Result channel: valid/ready handshake carrying one result word.
// Depends on pese_pkg.
`default_nettype none

interface pese_res_if;
	logic valid;
	logic ready;
	pese_pkg::res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/prefix_expression_stack_evaluator_top.sv]
// Evaluates prefix expressions on a stack: tokens arrive right to left. An
// operand is pushed; an operator pops two words and pushes its result. An
// add, subtract or multiply, and a divide or remainder with a zero divisor,
// use the ALU; any other divide or remainder uses the one-bit-per-cycle 32-step divider.
// A token marked last then adds the final pop and the result word,
// and that step waits while an earlier result word is still held, so a held
// word stalls the token side only at the end of an expression. A new token
// is taken only once the previous one is finished. The stack is a
// STACK_DEPTH-entry RAM with a registered read.
// Depends on pese_pkg, pese_tok_if, pese_res_if, pese_ctrl and pese_dpath.
`default_nettype none

module prefix_expression_stack_evaluator_top #(
	parameter int STACK_DEPTH = pese_pkg::STACK_DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	pese_tok_if.sink tok,
	pese_res_if.source res
);

	pese_pkg::cmd_t cmd;
	pese_pkg::sts_t sts;

	// Sequencer.
	pese_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (tok.valid),
		.tok_ready (tok.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Stack, arithmetic and output register.
	pese_dpath #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_data  (tok.data),
		.cmd       (cmd),
		.sts       (sts),
		.res_ready (res.ready),
		.res_valid (res.valid),
		.res_data  (res.data)
	);

endmodule

`default_nettype wire

[rtl/core/pese_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read
// that updates only when its read enable is high. No dependencies.
`default_nettype none

module pese_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write, and a registered read that holds its word between reads.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[rtl/core/pese_div.sv]
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on pese_pkg.
`default_nettype none

module pese_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [pese_pkg::DATA_W-1:0] dividend,
	input wire logic [pese_pkg::DATA_W-1:0] divisor,
	output logic done,
	output logic [pese_pkg::DATA_W-1:0] quotient,
	output logic [pese_pkg::DATA_W-1:0] remainder
);

	localparam int W = pese_pkg::DATA_W;
	localparam int CW = pese_pkg::DIV_CNT_W;

	logic busy_q;
	logic done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0] rem_q;
	logic [W-1:0] quo_q;
	logic [W-1:0] dvs_q;
	logic negq_q;
	logic negr_q;
	logic [W:0] shifted;
	logic [W:0] diff;
	logic [W-1:0] dividend_mag;
	logic [W-1:0] divisor_mag;

	// Magnitudes of the operands; the most negative value maps onto itself,
	// which reads correctly as an unsigned magnitude.
	assign dividend_mag = dividend[W-1] ? (~dividend + W'(1)) : dividend;
	assign divisor_mag = divisor[W-1] ? (~divisor + W'(1)) : divisor;

	// One restoring step: shift in the next dividend bit and try a subtract.
	assign shifted = {rem_q, quo_q[W-1]};
	assign diff = shifted - {1'b0, dvs_q};

	// Control: a start loads the operands, then W steps run.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CW'(1);
				end
			end
		end
	end

	// Partial remainder and quotient registers.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend_mag;
			dvs_q <= divisor_mag;
			negq_q <= dividend[W-1] ^ divisor[W-1];
			negr_q <= dividend[W-1];
		end else if (busy_q) begin
			if (!diff[W]) begin
				rem_q <= diff[W-1:0];
			end else begin
				rem_q <= shifted[W-1:0];
			end
			quo_q <= {quo_q[W-2:0], ~diff[W]};
		end
	end

	// Signs: the quotient is negative when the operand signs differ, the
	// remainder follows the dividend.
	assign done = done_q;
	assign quotient = negq_q ? (~quo_q + W'(1)) : quo_q;
	assign remainder = negr_q ? (~rem_q + W'(1)) : rem_q;

endmodule

`default_nettype wire

[rtl/core/pese_ctrl.sv]
// Controller state machine of the prefix expression evaluator.
// Depends on pese_pkg; drives the datapath through cmd_t and reads sts_t.
`default_nettype none

module pese_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic tok_valid,
	output logic tok_ready,
	input wire pese_pkg::sts_t sts,
	output pese_pkg::cmd_t cmd
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DECODE = 4'd1;
	localparam logic [3:0] ST_POPA = 4'd2;
	localparam logic [3:0] ST_POPB = 4'd3;
	localparam logic [3:0] ST_CAPB = 4'd4;
	localparam logic [3:0] ST_EXEC = 4'd5;
	localparam logic [3:0] ST_DIVW = 4'd6;
	localparam logic [3:0] ST_PUSHR = 4'd7;
	localparam logic [3:0] ST_FINAL = 4'd8;
	localparam logic [3:0] ST_EMIT = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_nxt;

	assign tok_ready = (state_q == ST_IDLE);

	// Next state and commands.
	always_comb begin
		state_nxt = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (tok_valid) begin
					cmd.load_tok = 1'b1;
					state_nxt = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (sts.kind == pese_pkg::KIND_OPERAND) begin
					cmd.push_opnd = 1'b1;
					state_nxt = sts.last ? ST_FINAL : ST_IDLE;
				end else if (sts.code_ok) begin
					state_nxt = ST_POPA;
				end else begin
					state_nxt = sts.last ? ST_FINAL : ST_IDLE;
				end
			end
			ST_POPA: begin
				cmd.pop = 1'b1;
				state_nxt = ST_POPB;
			end
			ST_POPB: begin
				cmd.cap_a = 1'b1;
				cmd.pop = 1'b1;
				state_nxt = ST_CAPB;
			end
			ST_CAPB: begin
				cmd.cap_b = 1'b1;
				state_nxt = ST_EXEC;
			end
			ST_EXEC: begin
				if (sts.is_div && !sts.b_zero) begin
					cmd.div_start = 1'b1;
					state_nxt = ST_DIVW;
				end else begin
					cmd.alu = 1'b1;
					state_nxt = ST_PUSHR;
				end
			end
			ST_DIVW: begin
				if (sts.div_done) begin
					cmd.div_cap = 1'b1;
					state_nxt = ST_PUSHR;
				end
			end
			ST_PUSHR: begin
				cmd.push_res = 1'b1;
				state_nxt = sts.last ? ST_FINAL : ST_IDLE;
			end
			ST_FINAL: begin
				cmd.pop = 1'b1;
				state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

[rtl/core/pese_dpath.sv]
// Datapath of the prefix expression evaluator: token register, stack RAM,
// count and sticky flags, ALU, divider and the output register.
// Depends on pese_pkg, pese_ram and pese_div.
`default_nettype none

module pese_dpath #(
	parameter int STACK_DEPTH = pese_pkg::STACK_DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire pese_pkg::tok_t tok_data,
	input wire pese_pkg::cmd_t cmd,
	output pese_pkg::sts_t sts,
	input wire logic res_ready,
	output logic res_valid,
	output pese_pkg::res_t res_data
);

	localparam int W = pese_pkg::DATA_W;
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	pese_pkg::tok_t tok_q;
	pese_pkg::res_t out_q;
	logic out_valid_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_m1;
	logic unf_q;
	logic ovf_q;
	logic dz_q;
	logic pop_empty_q;
	logic [W-1:0] a_q;
	logic [W-1:0] b_q;
	logic [W-1:0] r_q;
	logic [W-1:0] rdata;
	logic [W-1:0] pop_val;
	logic [W-1:0] push_val;
	logic push_en;
	logic full;
	logic we;
	logic div_done;
	logic [W-1:0] quotient;
	logic [W-1:0] remainder;

	// Stack addressing: push writes at the count, pop reads just below it.
	assign count_m1 = count_q - CW'(1);
	assign full = (count_q == CW'(STACK_DEPTH));
	assign push_en = cmd.push_opnd | cmd.push_res;
	assign push_val = cmd.push_opnd ? tok_q.operand_value : r_q;
	assign we = push_en & ~full;

	pese_ram #(
		.WIDTH (W),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (we),
		.waddr (count_q[AW-1:0]),
		.wdata (push_val),
		.re    (cmd.pop),
		.raddr (count_m1[AW-1:0]),
		.rdata (rdata)
	);

	// A pop of an empty stack reads as all ones.
	assign pop_val = pop_empty_q ? '1 : rdata;

	pese_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (a_q),
		.divisor   (b_q),
		.done      (div_done),
		.quotient  (quotient),
		.remainder (remainder)
	);

	// Token register.
	always_ff @(posedge clk) begin
		if (cmd.load_tok) begin
			tok_q <= tok_data;
		end
	end

	// Operand capture and result register.
	always_ff @(posedge clk) begin
		if (cmd.cap_a) begin
			a_q <= pop_val;
		end
		if (cmd.cap_b) begin
			b_q <= pop_val;
		end
		if (cmd.alu) begin
			case (tok_q.operator_code)
				pese_pkg::OP_ADD: r_q <= a_q + b_q;
				pese_pkg::OP_MUL: r_q <= a_q * b_q;
				pese_pkg::OP_SUB: r_q <= a_q - b_q;
				default: r_q <= '0;
			endcase
		end else if (cmd.div_cap) begin
			r_q <= (tok_q.operator_code == pese_pkg::OP_DIV) ? quotient : remainder;
		end
	end

	// Stack count and sticky flags; the emit clears them for the next expression.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			unf_q <= 1'b0;
			ovf_q <= 1'b0;
			dz_q <= 1'b0;
			pop_empty_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				count_q <= '0;
				unf_q <= 1'b0;
				ovf_q <= 1'b0;
				dz_q <= 1'b0;
			end else if (push_en) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + CW'(1);
				end
			end else if (cmd.pop) begin
				pop_empty_q <= (count_q == '0);
				if (count_q == '0) begin
					unf_q <= 1'b1;
				end else begin
					count_q <= count_m1;
				end
			end
			// The ALU only sees a divide code when the divisor is zero.
			if (cmd.alu && sts.is_div) begin
				dz_q <= 1'b1;
			end
		end
	end

	// Output register; a held word is released by the consumer's ready.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.result_value <= pop_val;
			out_q.underflow_seen <= unf_q;
			out_q.overflow_seen <= ovf_q;
			out_q.divide_by_zero_seen <= dz_q;
		end
	end

	assign res_valid = out_valid_q;
	assign res_data = out_q;

	// Status for the controller.
	assign sts.kind = tok_q.kind;
	assign sts.code_ok = (tok_q.operator_code <= pese_pkg::OP_REM);
	assign sts.is_div = (tok_q.operator_code == pese_pkg::OP_DIV) ||
		(tok_q.operator_code == pese_pkg::OP_REM);
	assign sts.last = tok_q.last_token;
	assign sts.b_zero = (b_q == '0);
	assign sts.div_done = div_done;
	assign sts.out_free = ~out_valid_q | res_ready;

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for prefix_expression_stack_evaluator_top: a stack
// predictor in a small scoreboard class, and plain tasks for tokens and results.
// Depends on pese_pkg, pese_tok_if, pese_res_if and the evaluator RTL.

// Tracks the evaluation stack and sticky flags, and holds the result words
// still owed by the block.
class prefix_scoreboard;
	logic [pese_pkg::DATA_W-1:0] stack_mem [pese_pkg::STACK_DEPTH_DEF];
	int unsigned level;
	bit underflow;
	bit overflow;
	bit divzero;
	pese_pkg::res_t pending_results[$];
	int fails;

	function new();
		level = 0;
		underflow = 0;
		overflow = 0;
		divzero = 0;
		fails = 0;
	endfunction

	// Prints one line per mismatch.
	task report(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		fails++;
	endtask

	function void push_word(input logic [pese_pkg::DATA_W-1:0] v);
		if (level >= pese_pkg::STACK_DEPTH_DEF) begin
			overflow = 1;
			return;
		end
		stack_mem[level] = v;
		level++;
	endfunction

	function logic [pese_pkg::DATA_W-1:0] pop_word();
		if (level == 0) begin
			underflow = 1;
			return '1;
		end
		level--;
		return stack_mem[level];
	endfunction

	// Arithmetic wraps at 32 bits; division truncates toward zero and the
	// remainder follows the sign of the dividend.
	function logic [pese_pkg::DATA_W-1:0] apply_op(input logic [pese_pkg::CODE_W-1:0] code,
			input logic [pese_pkg::DATA_W-1:0] a, input logic [pese_pkg::DATA_W-1:0] b);
		longint dividend;
		longint divisor;
		longint q;
		case (code)
			pese_pkg::OP_ADD: return a + b;
			pese_pkg::OP_MUL: return a * b;
			pese_pkg::OP_SUB: return a - b;
			default: begin
				if (b == 0) begin
					divzero = 1;
					return '0;
				end
				dividend = $signed(a);
				divisor = $signed(b);
				q = (code == pese_pkg::OP_DIV) ? dividend / divisor : dividend % divisor;
				return pese_pkg::DATA_W'(q);
			end
		endcase
	endfunction

	// Updates the stack for one accepted token word and queues the result word
	// that a last token owes.
	function void evaluate_token(input pese_pkg::tok_t t);
		logic [pese_pkg::DATA_W-1:0] a;
		logic [pese_pkg::DATA_W-1:0] b;
		pese_pkg::res_t r;
		if (t.kind == pese_pkg::KIND_OPERAND) begin
			push_word(t.operand_value);
		end else if (t.operator_code <= pese_pkg::OP_REM) begin
			a = pop_word();
			b = pop_word();
			push_word(apply_op(t.operator_code, a, b));
		end
		if (t.last_token) begin
			r.result_value = pop_word();
			r.underflow_seen = underflow;
			r.overflow_seen = overflow;
			r.divide_by_zero_seen = divzero;
			pending_results.push_back(r);
			level = 0;
			underflow = 0;
			overflow = 0;
			divzero = 0;
		end
	endfunction

	// Compares a result word with the oldest one owed, field by field.
	task check_result(input pese_pkg::res_t got);
		pese_pkg::res_t want;
		if (pending_results.size() == 0) begin
			report($sformatf("unexpected result word value %0d", got.result_value));
			return;
		end
		want = pending_results.pop_front();
		if (got.result_value !== want.result_value)
			report($sformatf("result_value %0d, expected %0d",
				got.result_value, want.result_value));
		if (got.underflow_seen !== want.underflow_seen)
			report($sformatf("underflow_seen %b, expected %b",
				got.underflow_seen, want.underflow_seen));
		if (got.overflow_seen !== want.overflow_seen)
			report($sformatf("overflow_seen %b, expected %b",
				got.overflow_seen, want.overflow_seen));
		if (got.divide_by_zero_seen !== want.divide_by_zero_seen)
			report($sformatf("divide_by_zero_seen %b, expected %b",
				got.divide_by_zero_seen, want.divide_by_zero_seen));
	endtask

	task check_drained();
		if (pending_results.size() != 0)
			report($sformatf("%0d result words never arrived", pending_results.size()));
	endtask
endclass

module tb;
	// Codes 5 to 7 are not operators; the block must leave its stack alone for them.
	localparam logic [pese_pkg::CODE_W-1:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [pese_pkg::CODE_W-1:0] OP_SPARE_LAST = 3'd7;

	logic clk;
	logic arst_n;
	pese_tok_if tok_ch ();
	pese_res_if res_ch ();

	prefix_scoreboard sb = new();

	int send_idle_pct;
	int recv_stall_pct;
	int hold_req;
	int hold_left;
	int sent_tokens;

	prefix_expression_stack_evaluator_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.tok(tok_ch),
		.res(res_ch)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#1_000_000;
		$display("** prefix_expression_stack_evaluator_top: FAILED **");
		$finish;
	end

	// Offers one token word, with random idle cycles ahead of it, and hands it
	// to the scoreboard once the block takes it.
	task automatic put_token(input pese_pkg::tok_t t);
		while ($urandom_range(99) < send_idle_pct) begin
			tok_ch.valid <= 1'b0;
			@(posedge clk);
		end
		tok_ch.valid <= 1'b1;
		tok_ch.data <= t;
		do
			@(posedge clk);
		while (!tok_ch.ready);
		sb.evaluate_token(t);
		sent_tokens++;
	endtask

	// An operand token; the unused code field gets random bits.
	task automatic push_operand(input logic [pese_pkg::DATA_W-1:0] v, input logic last);
		pese_pkg::tok_t t;
		t.kind = pese_pkg::KIND_OPERAND;
		t.operand_value = v;
		t.operator_code = pese_pkg::CODE_W'($urandom_range(OP_SPARE_LAST));
		t.last_token = last;
		put_token(t);
	endtask

	// An operator token; the unused value field gets random bits.
	task automatic apply_operator(input logic [pese_pkg::CODE_W-1:0] code, input logic last);
		pese_pkg::tok_t t;
		t.kind = pese_pkg::KIND_OPERATOR;
		t.operand_value = $urandom;
		t.operator_code = code;
		t.last_token = last;
		put_token(t);
	endtask

	// Operand values lean toward digits, zero and the extremes.
	function automatic logic [pese_pkg::DATA_W-1:0] pick_value();
		case ($urandom_range(9))
			0, 1, 2: return $urandom_range(9);
			3: return '0;
			4: begin
				case ($urandom_range(3))
					0: return 32'h8000_0000;
					1: return 32'h7fff_ffff;
					2: return '1;
					default: return 32'd1;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [pese_pkg::CODE_W-1:0] pick_code();
		return pese_pkg::CODE_W'($urandom_range(pese_pkg::OP_ADD, pese_pkg::OP_REM));
	endfunction

	// One random sequence: mostly well-formed expressions, some that overrun
	// the stack, and some scrambled tokens with spare codes and stray last marks.
	task automatic emit_sequence();
		int unsigned pick;
		int unsigned ops_left;
		int unsigned opnds_left;
		int unsigned held;
		int unsigned k;
		pese_pkg::tok_t t;
		pick = $urandom_range(99);
		if (pick < 75) begin
			ops_left = ($urandom_range(3) == 0) ? $urandom_range(7) : $urandom_range(3);
			opnds_left = ops_left + 1;
			held = 0;
			while (ops_left + opnds_left > 0) begin
				if (opnds_left > 0 && (held < 2 || ops_left == 0 || $urandom_range(1) == 1)) begin
					opnds_left--;
					held++;
					push_operand(pick_value(), (ops_left + opnds_left) == 0);
				end else begin
					ops_left--;
					held--;
					apply_operator(pick_code(), (ops_left + opnds_left) == 0);
				end
			end
		end else if (pick < 82) begin
			k = $urandom_range(pese_pkg::STACK_DEPTH_DEF - 1, pese_pkg::STACK_DEPTH_DEF + 4);
			repeat (k) push_operand(pick_value(), 1'b0);
			apply_operator(pick_code(), 1'b1);
		end else begin
			k = $urandom_range(1, 6);
			repeat (k) begin
				t.kind = 1'($urandom_range(1));
				t.operand_value = pick_value();
				t.operator_code = pese_pkg::CODE_W'($urandom_range(OP_SPARE_LAST));
				t.last_token = ($urandom_range(3) == 0);
				put_token(t);
			end
		end
	endtask

	// Drops valid and waits until every owed result word has come back.
	task automatic drain();
		tok_ch.valid <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
		int target;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		target = sent_tokens + count;
		while (sent_tokens < target)
			emit_sequence();
		drain();
	endtask

	// Result side: checks each accepted word, then picks ready for the next
	// cycle, honoring a requested long hold-off.
	initial begin
		hold_left = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_ch.valid && res_ch.ready)
				sb.check_result(res_ch.data);
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Token side: reset, directed cases, random phases, then the final check.
	initial begin
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req = 0;
		sent_tokens = 0;
		arst_n <= 1'b0;
		tok_ch.valid <= 1'b0;
		tok_ch.data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Operator on an empty stack: both pops underflow.
		apply_operator(pese_pkg::OP_ADD, 1'b1);
		// Lone operands at the extremes.
		push_operand(32'h7fff_ffff, 1'b1);
		push_operand(32'h8000_0000, 1'b1);
		// Most negative over minus one, for quotient and remainder.
		push_operand('1, 1'b0);
		push_operand(32'h8000_0000, 1'b0);
		apply_operator(pese_pkg::OP_DIV, 1'b1);
		push_operand('1, 1'b0);
		push_operand(32'h8000_0000, 1'b0);
		apply_operator(pese_pkg::OP_REM, 1'b1);
		// Zero divisor.
		push_operand('0, 1'b0);
		push_operand(32'd7, 1'b0);
		apply_operator(pese_pkg::OP_DIV, 1'b1);
		// Remainder keeps the sign of the dividend.
		push_operand(32'd3, 1'b0);
		push_operand(-32'sd7, 1'b0);
		apply_operator(pese_pkg::OP_REM, 1'b1);
		// Wrapping multiply, add and subtract.
		push_operand(32'd65536, 1'b0);
		push_operand(32'd65536, 1'b0);
		apply_operator(pese_pkg::OP_MUL, 1'b1);
		push_operand(32'd1, 1'b0);
		push_operand(32'h7fff_ffff, 1'b0);
		apply_operator(pese_pkg::OP_ADD, 1'b1);
		push_operand(32'd5, 1'b0);
		push_operand(32'd3, 1'b0);
		apply_operator(pese_pkg::OP_SUB, 1'b1);
		// Spare codes leave the stack as it is, even on the last token.
		push_operand(32'd4, 1'b0);
		apply_operator(OP_SPARE_LAST, 1'b0);
		apply_operator(OP_SPARE_FIRST, 1'b1);
		drain();

		run_phase(0, 0, 210);
		run_phase(57, 0, 210);
		run_phase(0, 57, 210);
		run_phase(9, 9, 210);

		// Results held back for a long stretch while short expressions keep
		// coming, so the held result word stalls the token side.
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req = 400;
		repeat (30) begin
			push_operand(pick_value(), 1'b0);
			push_operand(pick_value(), 1'b0);
			apply_operator(pick_code(), 1'b1);
		end
		drain();

		repeat (60) @(posedge clk);
		sb.check_drained();
		if (sb.fails == 0)
			$display("** prefix_expression_stack_evaluator_top: PASSED **");
		else
			$display("** prefix_expression_stack_evaluator_top: FAILED **");
		$finish;
	end
endmodule
